FILE: rtl/battery_soc_estimator_top_defines.svh
// assertion macros for the battery state-of-charge estimator
`ifndef BATTERY_SOC_ESTIMATOR_TOP_DEFINES_SVH
`define BATTERY_SOC_ESTIMATOR_TOP_DEFINES_SVH

// condition must hold in the same cycle as the trigger
`define BSE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition must hold in the cycle after the trigger
`define BSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bse_pkg.sv
// shared types, widths and constants of the battery state-of-charge estimator
package bse_pkg;

  localparam int FRAC_BITS   = 8;
  localparam int SOC_W       = 15;
  localparam int CAP_W       = 16;
  localparam int VOLT_W      = 15;
  localparam int CUR_W       = 16;
  localparam int ELAPSED_W   = 32;
  localparam int ALPHA_W     = 9;
  localparam int BSTATE_W    = 2;
  localparam int CHARGE_W    = 38;
  localparam int REG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam int DELTA_W     = CUR_W + ELAPSED_W;
  localparam int SUM_W       = DELTA_W + 1;
  localparam int VNUM_W      = VOLT_W + SOC_W;
  localparam int SEEDP_W     = SOC_W + CAP_W;
  localparam int SEED_SHIFT  = 5;
  localparam int SEED_W      = SEEDP_W + 11 + SEED_SHIFT;
  localparam int ALPHA_SHIFT = ALPHA_W - 1;
  localparam int BLEND_W     = SOC_W + ALPHA_W + 3;

  localparam int DIV_N_W     = CHARGE_W + FRAC_BITS;
  localparam int DIV_D_W     = 32;
  localparam int QUOT_W      = SOC_W;
  localparam int DIV_CNT_W   = $clog2(QUOT_W + 1);

  localparam logic [SOC_W-1:0]   FULL_SOC    = SOC_W'(100 << FRAC_BITS);
  localparam logic [SOC_W-1:0]   HALF_SOC    = SOC_W'(50 << FRAC_BITS);
  localparam logic [21:0]        MS_PER_HOUR = 22'd3600000;
  // one percent of an hour in ms, divisor scale of the charge ratio
  localparam logic [15:0]        COUL_SCALE  = 16'd36000;
  // COUL_SCALE >> SEED_SHIFT
  localparam logic [10:0]        SEED_SCALE  = 11'd1125;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = ALPHA_W'(1 << ALPHA_SHIFT);

  localparam logic [REG_IDX_W-1:0] REG_CAPACITY    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_VOLTAGE_MIN = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_VOLTAGE_MAX = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_IDLE_THRESH = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ALPHA_ACT   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_ALPHA_IDLE  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_STATUS_BAND = 3'd6;

  localparam logic [BSTATE_W-1:0] BS_IDLE        = 2'd0;
  localparam logic [BSTATE_W-1:0] BS_CHARGING    = 2'd1;
  localparam logic [BSTATE_W-1:0] BS_DISCHARGING = 2'd2;

  typedef struct packed {
    logic [CAP_W-1:0]   capacity_mah;
    logic [VOLT_W-1:0]  voltage_min_mv;
    logic [VOLT_W-1:0]  voltage_max_mv;
    logic [CUR_W-2:0]   idle_threshold_ma;
    logic [ALPHA_W-1:0] alpha_active;
    logic [ALPHA_W-1:0] alpha_idle;
    logic [CUR_W-2:0]   status_band_ma;
  } cfg_t;

  typedef struct packed {
    logic load_item;
    logic prep;
    logic vdiv_start;
    logic vsoc_take;
    logic charge_upd;
    logic seed;
    logic cdiv_start;
    logic csoc_take;
    logic blend;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic start_item;
    logic seed_idle;
    logic cdiv_skip;
    logic div_busy;
  } dp_status_t;

endpackage

FILE: rtl/bse_div.sv
// restoring divider, one quotient bit per cycle
module bse_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [bse_pkg::DIV_N_W-1:0]  numer,
  input  logic [bse_pkg::DIV_D_W-1:0]  denom,
  output logic                         busy,
  output logic [bse_pkg::QUOT_W-1:0]   quot
);
  import bse_pkg::*;

  logic [DIV_D_W-1:0]   rem;
  logic [DIV_D_W-1:0]   dvs;
  logic [QUOT_W-1:0]    qsr;
  logic [DIV_CNT_W-1:0] count;
  logic [DIV_D_W:0]     trial;
  logic [DIV_D_W:0]     diff;

  always_comb begin
    trial = {rem, qsr[QUOT_W-1]};
    diff  = trial - {1'b0, dvs};
  end

  assign busy = (count != '0);
  assign quot = qsr;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= DIV_CNT_W'(QUOT_W);
    end else if (busy) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= DIV_D_W'(numer >> QUOT_W);
      qsr <= numer[QUOT_W-1:0];
      dvs <= denom;
    end else if (busy) begin
      if (!diff[DIV_D_W]) begin
        rem <= diff[DIV_D_W-1:0];
        qsr <= {qsr[QUOT_W-2:0], 1'b1};
      end else begin
        rem <= trial[DIV_D_W-1:0];
        qsr <= {qsr[QUOT_W-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: rtl/bse_ctrl.sv
// sequencing state machine of the battery state-of-charge estimator
module bse_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  bse_pkg::dp_status_t    status,
  output bse_pkg::ctrl_cmd_t     cmd
);
  import bse_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_PREP   = 4'd1;
  localparam logic [3:0] ST_VLOAD  = 4'd2;
  localparam logic [3:0] ST_VWAIT  = 4'd3;
  localparam logic [3:0] ST_CHARGE = 4'd4;
  localparam logic [3:0] ST_SEED   = 4'd5;
  localparam logic [3:0] ST_CLOAD  = 4'd6;
  localparam logic [3:0] ST_CWAIT  = 4'd7;
  localparam logic [3:0] ST_BLEND  = 4'd8;
  localparam logic [3:0] ST_DONE   = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = ST_VLOAD;
      end
      ST_VLOAD: begin
        cmd.vdiv_start = 1'b1;
        state_next     = ST_VWAIT;
      end
      ST_VWAIT: begin
        if (!status.div_busy) begin
          cmd.vsoc_take = 1'b1;
          state_next    = ST_CHARGE;
        end
      end
      ST_CHARGE: begin
        cmd.charge_upd = 1'b1;
        if (status.start_item && status.seed_idle) begin
          state_next = ST_SEED;
        end else begin
          state_next = ST_CLOAD;
        end
      end
      ST_SEED: begin
        cmd.seed   = 1'b1;
        state_next = ST_CLOAD;
      end
      ST_CLOAD: begin
        cmd.cdiv_start = 1'b1;
        if (status.cdiv_skip) begin
          state_next = ST_BLEND;
        end else begin
          state_next = ST_CWAIT;
        end
      end
      ST_CWAIT: begin
        if (!status.div_busy) begin
          cmd.csoc_take = 1'b1;
          state_next    = ST_BLEND;
        end
      end
      ST_BLEND: begin
        cmd.blend  = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/bse_dp.sv
// datapath: charge counter, soc arithmetic and result register
module bse_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  bse_pkg::cfg_t                      cfg,
  input  bse_pkg::ctrl_cmd_t                 cmd,
  output bse_pkg::dp_status_t                status,
  input  logic                               start_flag,
  input  logic [bse_pkg::ELAPSED_W-1:0]      elapsed_ms,
  input  logic signed [bse_pkg::CUR_W-1:0]   battery_current_ma,
  input  logic [bse_pkg::VOLT_W-1:0]         battery_voltage_mv,
  output logic [bse_pkg::SOC_W-1:0]          combined_soc,
  output logic [bse_pkg::SOC_W-1:0]          coulomb_soc,
  output logic [bse_pkg::SOC_W-1:0]          voltage_soc,
  output logic [bse_pkg::BSTATE_W-1:0]       battery_state
);
  import bse_pkg::*;

  // latched beat
  logic                      start_item;
  logic [ELAPSED_W-1:0]      elapsed;
  logic signed [CUR_W-1:0]   cur;
  logic [VOLT_W-1:0]         volt;

  // prepared operands
  logic [VOLT_W-1:0]         vclamp;
  logic [VOLT_W-1:0]         span;
  logic                      span_empty;
  logic [CHARGE_W-1:0]       cap;
  logic [DIV_D_W-1:0]        dcoul;
  logic signed [DELTA_W-1:0] delta;
  logic                      mag_lt;
  logic                      mag_gt;
  logic [BSTATE_W-1:0]       bstate;

  logic [SOC_W-1:0]          vsoc;
  logic [SOC_W-1:0]          csoc;
  logic [SEEDP_W-1:0]        seedprod;
  logic [CHARGE_W-1:0]       charge;
  logic [SOC_W-1:0]          level;

  logic [SOC_W-1:0]          out_comb;
  logic [SOC_W-1:0]          out_coul;
  logic [SOC_W-1:0]          out_volt;
  logic [BSTATE_W-1:0]       out_state;

  // combinational helpers
  logic [CUR_W-1:0]          mag;
  logic [CUR_W-1:0]          thr;
  logic [VOLT_W-1:0]         vhi;
  logic [VOLT_W-1:0]         vclamp_next;
  logic signed [DELTA_W-1:0] cur_w;
  logic signed [DELTA_W-1:0] el_w;
  logic signed [CUR_W:0]     cur_x;
  logic signed [CUR_W:0]     band_x;
  logic [BSTATE_W-1:0]       bstate_next;
  logic [VNUM_W-1:0]         vnum;
  logic signed [SUM_W-1:0]   charge_s;
  logic signed [SUM_W-1:0]   delta_s;
  logic signed [SUM_W-1:0]   cap_s;
  logic signed [SUM_W-1:0]   sum;
  logic [CHARGE_W-1:0]       charge_clamped;
  logic [SEED_W-1:0]         seed_full;
  logic [CHARGE_W-1:0]       seed_charge;
  logic                      cap_zero;
  logic                      cdiv_skip;
  logic [ALPHA_W-1:0]        a_sel;
  logic [ALPHA_W-1:0]        a_sat;
  logic signed [BLEND_W-1:0] a_s;
  logic signed [BLEND_W-1:0] soc_diff;
  logic signed [BLEND_W-1:0] blend;
  logic [SOC_W-1:0]          blend_level;

  logic                      div_start;
  logic [DIV_N_W-1:0]        div_numer;
  logic [DIV_D_W-1:0]        div_denom;
  logic                      div_busy;
  logic [QUOT_W-1:0]         div_quot;

  always_comb begin
    mag = cur[CUR_W-1] ? CUR_W'(-cur) : CUR_W'(cur);
    thr = CUR_W'(cfg.idle_threshold_ma);

    vhi         = (volt > cfg.voltage_max_mv) ? cfg.voltage_max_mv : volt;
    vclamp_next = (vhi < cfg.voltage_min_mv) ? cfg.voltage_min_mv : vhi;

    cur_w = DELTA_W'(cur);
    el_w  = DELTA_W'(elapsed);

    cur_x  = (CUR_W + 1)'(cur);
    band_x = (CUR_W + 1)'(cfg.status_band_ma);
    if (cur_x > band_x) begin
      bstate_next = BS_CHARGING;
    end else if (cur_x < -band_x) begin
      bstate_next = BS_DISCHARGING;
    end else begin
      bstate_next = BS_IDLE;
    end

    vnum = VNUM_W'(vclamp - cfg.voltage_min_mv) * VNUM_W'(FULL_SOC);

    charge_s = SUM_W'(charge);
    delta_s  = SUM_W'(delta);
    cap_s    = SUM_W'(cap);
    sum      = charge_s + delta_s;
    if (sum[SUM_W-1]) begin
      charge_clamped = '0;
    end else if (sum > cap_s) begin
      charge_clamped = cap;
    end else begin
      charge_clamped = sum[CHARGE_W-1:0];
    end

    seed_full   = (SEED_W'(seedprod) * SEED_W'(SEED_SCALE)) << SEED_SHIFT;
    seed_charge = CHARGE_W'(seed_full >> FRAC_BITS);

    cap_zero  = (cfg.capacity_mah == '0);
    cdiv_skip = cap_zero || (charge >= cap);

    a_sel       = mag_gt ? cfg.alpha_active : cfg.alpha_idle;
    a_sat       = (a_sel > ALPHA_ONE) ? ALPHA_ONE : a_sel;
    a_s         = BLEND_W'(a_sat);
    soc_diff    = BLEND_W'(csoc) - BLEND_W'(vsoc);
    blend       = (BLEND_W'(vsoc) <<< ALPHA_SHIFT) + a_s * soc_diff;
    blend_level = blend[ALPHA_SHIFT +: SOC_W];

    div_start = cmd.vdiv_start || (cmd.cdiv_start && !cdiv_skip);
    if (cmd.vdiv_start) begin
      div_numer = DIV_N_W'(vnum);
      div_denom = DIV_D_W'(span);
    end else begin
      div_numer = DIV_N_W'(charge) << FRAC_BITS;
      div_denom = dcoul;
    end
  end

  assign status.start_item = start_item;
  assign status.seed_idle  = mag_lt;
  assign status.cdiv_skip  = cdiv_skip;
  assign status.div_busy   = div_busy;

  bse_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (div_numer),
    .denom (div_denom),
    .busy  (div_busy),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      start_item <= start_flag;
      elapsed    <= elapsed_ms;
      cur        <= battery_current_ma;
      volt       <= battery_voltage_mv;
    end
    if (cmd.prep) begin
      vclamp     <= vclamp_next;
      span       <= cfg.voltage_max_mv - cfg.voltage_min_mv;
      span_empty <= (cfg.voltage_max_mv <= cfg.voltage_min_mv);
      cap        <= CHARGE_W'(cfg.capacity_mah) * CHARGE_W'(MS_PER_HOUR);
      dcoul      <= DIV_D_W'(cfg.capacity_mah) * DIV_D_W'(COUL_SCALE);
      delta      <= cur_w * el_w;
      mag_lt     <= (mag < thr);
      mag_gt     <= (mag > thr);
      bstate     <= bstate_next;
    end
    if (cmd.vsoc_take) begin
      vsoc <= span_empty ? '0 : div_quot;
    end
    if (cmd.charge_upd) begin
      seedprod <= SEEDP_W'(vsoc) * SEEDP_W'(cfg.capacity_mah);
    end
    if (cmd.cdiv_start && cdiv_skip) begin
      csoc <= cap_zero ? '0 : FULL_SOC;
    end
    if (cmd.csoc_take) begin
      csoc <= div_quot;
    end
    if (cmd.emit) begin
      out_comb  <= level;
      out_coul  <= csoc;
      out_volt  <= vsoc;
      out_state <= bstate;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      charge <= '0;
      level  <= '0;
    end else begin
      if (cmd.charge_upd) begin
        if (!start_item) begin
          charge <= charge_clamped;
        end else if (!mag_lt) begin
          charge <= cap >> 1;
          level  <= HALF_SOC;
        end
      end
      if (cmd.seed) begin
        charge <= seed_charge;
        level  <= vsoc;
      end
      if (cmd.blend && !start_item) begin
        level <= blend_level;
      end
    end
  end

  assign combined_soc  = out_comb;
  assign coulomb_soc   = out_coul;
  assign voltage_soc   = out_volt;
  assign battery_state = out_state;

endmodule

FILE: rtl/battery_soc_estimator_top.sv
// Battery state-of-charge estimator: counts charge in mA-ms from current and elapsed
// time, clamped to the configured capacity, and reports coulomb, voltage and blended
// SOC in percent Q7.8 with a charging/idle/discharging class. One beat in gives one
// beat out. From acceptance until its result is offered and the next item can be taken,
// an item makes two 15-step passes of the shared restoring divider (voltage ratio, then
// charge ratio); the charge pass is skipped when the capacity is zero or the charge
// sits at full capacity. The finished result waits in an output register, so the next
// beat is accepted while it is still pending.
// Configuration writes are taken every cycle and must only happen while no item is
// in flight.
`include "battery_soc_estimator_top_defines.svh"

module battery_soc_estimator_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bse_pkg::REG_IDX_W-1:0]        cfg_index,
  input  logic [bse_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 start_flag,
  input  logic [bse_pkg::ELAPSED_W-1:0]        elapsed_ms,
  input  logic signed [bse_pkg::CUR_W-1:0]     battery_current_ma,
  input  logic [bse_pkg::VOLT_W-1:0]           battery_voltage_mv,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [bse_pkg::SOC_W-1:0]            combined_soc,
  output logic [bse_pkg::SOC_W-1:0]            coulomb_soc,
  output logic [bse_pkg::SOC_W-1:0]            voltage_soc,
  output logic [bse_pkg::BSTATE_W-1:0]         battery_state
);
  import bse_pkg::*;

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.capacity_mah      <= CAP_W'(7000);
      cfg.voltage_min_mv    <= VOLT_W'(3000);
      cfg.voltage_max_mv    <= VOLT_W'(4200);
      cfg.idle_threshold_ma <= (CUR_W - 1)'(50);
      cfg.alpha_active      <= ALPHA_W'(230);
      cfg.alpha_idle        <= ALPHA_W'(51);
      cfg.status_band_ma    <= (CUR_W - 1)'(50);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CAPACITY:    cfg.capacity_mah      <= cfg_data;
        REG_VOLTAGE_MIN: cfg.voltage_min_mv    <= cfg_data[VOLT_W-1:0];
        REG_VOLTAGE_MAX: cfg.voltage_max_mv    <= cfg_data[VOLT_W-1:0];
        REG_IDLE_THRESH: cfg.idle_threshold_ma <= cfg_data[CUR_W-2:0];
        REG_ALPHA_ACT:   cfg.alpha_active      <= cfg_data[ALPHA_W-1:0];
        REG_ALPHA_IDLE:  cfg.alpha_idle        <= cfg_data[ALPHA_W-1:0];
        REG_STATUS_BAND: cfg.status_band_ma    <= cfg_data[CUR_W-2:0];
        default: begin
        end
      endcase
    end
  end

  bse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  bse_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .cfg                (cfg),
    .cmd                (cmd),
    .status             (status),
    .start_flag         (start_flag),
    .elapsed_ms         (elapsed_ms),
    .battery_current_ma (battery_current_ma),
    .battery_voltage_mv (battery_voltage_mv),
    .combined_soc       (combined_soc),
    .coulomb_soc        (coulomb_soc),
    .voltage_soc        (voltage_soc),
    .battery_state      (battery_state)
  );

  `BSE_ASSERT_NEXT(a_busy_after_beat, in_valid && in_ready, !in_ready, "input taken while busy")
  `BSE_ASSERT_NEXT(a_div_launch, cmd.vdiv_start, status.div_busy, "divider did not start")
  `BSE_ASSERT_NOW(a_soc_range, out_valid, (combined_soc <= FULL_SOC) && (coulomb_soc <= FULL_SOC) && (voltage_soc <= FULL_SOC), "soc above full scale")

endmodule

FILE: tb/tb_battery_soc_estimator_top.sv
// self-checking testbench for the battery state-of-charge estimator with handshake idling
module tb_battery_soc_estimator_top;
  import bse_pkg::*;

  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 64;
  localparam int REPORT_MAX    = 10;

  typedef struct {
    bit                        seed;
    logic [ELAPSED_W-1:0]      ms;
    logic signed [CUR_W-1:0]   cur_ma;
    logic [VOLT_W-1:0]         mv;
  } soc_item_t;

  typedef struct {
    logic [SOC_W-1:0]    combined;
    logic [SOC_W-1:0]    coulomb;
    logic [SOC_W-1:0]    voltage;
    logic [BSTATE_W-1:0] bstate;
  } soc_result_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [REG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    start_flag = 1'b0;
  logic [ELAPSED_W-1:0]    elapsed_ms = '0;
  logic signed [CUR_W-1:0] battery_current_ma = '0;
  logic [VOLT_W-1:0]       battery_voltage_mv = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [SOC_W-1:0]        combined_soc;
  logic [SOC_W-1:0]        coulomb_soc;
  logic [SOC_W-1:0]        voltage_soc;
  logic [BSTATE_W-1:0]     battery_state;

  // register copies
  logic [CAP_W-1:0]   cap_mah     = 16'd7000;
  logic [VOLT_W-1:0]  vmin_mv     = 15'd3000;
  logic [VOLT_W-1:0]  vmax_mv     = 15'd4200;
  logic [VOLT_W-1:0]  idle_thr_ma = 15'd50;
  logic [ALPHA_W-1:0] alpha_act   = 9'd230;
  logic [ALPHA_W-1:0] alpha_rest  = 9'd51;
  logic [VOLT_W-1:0]  band_ma     = 15'd50;

  // charge in mA-ms and last blended level
  longint             charge_mams = 0;
  logic [SOC_W-1:0]   blended_level = '0;

  soc_item_t   pending_q[$];
  soc_result_t soc_expected_q[$];
  soc_item_t   next_item;
  soc_result_t want;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          mismatches = 0;
  int          quiet_cycles = 0;

  battery_soc_estimator_top i_dut (
    .clk                (clk),
    .rst                (rst),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .start_flag         (start_flag),
    .elapsed_ms         (elapsed_ms),
    .battery_current_ma (battery_current_ma),
    .battery_voltage_mv (battery_voltage_mv),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .combined_soc       (combined_soc),
    .coulomb_soc        (coulomb_soc),
    .voltage_soc        (voltage_soc),
    .battery_state      (battery_state)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic soc_result_t predict_soc(input logic seed, input logic [ELAPSED_W-1:0] ms,
                                              input logic signed [CUR_W-1:0] cur_ma,
                                              input logic [VOLT_W-1:0] mv);
    soc_result_t r;
    longint cur, mag, cap, full, v, vlo, vhi, vsoc, csoc, a, band;
    cur  = longint'(cur_ma);
    mag  = (cur < 0) ? -cur : cur;
    cap  = longint'(cap_mah) * 64'd3600000;
    full = longint'(FULL_SOC);
    vlo  = longint'(vmin_mv);
    vhi  = longint'(vmax_mv);
    band = longint'(band_ma);
    if (vhi <= vlo) begin
      vsoc = 0;
    end else begin
      v = longint'(mv);
      if (v > vhi) v = vhi;
      if (v < vlo) v = vlo;
      vsoc = ((v - vlo) * full) / (vhi - vlo);
      if (vsoc > full) vsoc = full;
    end
    if (seed) begin
      if (mag < longint'(idle_thr_ma)) begin
        charge_mams   = (cap > 0) ? (vsoc * cap) / full : 0;
        blended_level = SOC_W'(vsoc);
      end else begin
        charge_mams   = cap / 2;
        blended_level = HALF_SOC;
      end
    end else begin
      charge_mams += cur * longint'(ms);
      if (charge_mams > cap) charge_mams = cap;
      if (charge_mams < 0) charge_mams = 0;
    end
    if (cap <= 0 || charge_mams <= 0) begin
      csoc = 0;
    end else begin
      csoc = (charge_mams * full) / cap;
      if (csoc > full) csoc = full;
    end
    if (!seed) begin
      a = (mag > longint'(idle_thr_ma)) ? longint'(alpha_act) : longint'(alpha_rest);
      if (a > 256) a = 256;
      blended_level = SOC_W'((a * csoc + (256 - a) * vsoc) >> 8);
    end
    r.combined = blended_level;
    r.coulomb  = SOC_W'(csoc);
    r.voltage  = SOC_W'(vsoc);
    if (cur > band) r.bstate = BS_CHARGING;
    else if (cur < -band) r.bstate = BS_DISCHARGING;
    else r.bstate = BS_IDLE;
    return r;
  endfunction

  function automatic soc_item_t random_item();
    soc_item_t it;
    int sel, m, t, lo, hi;
    it.seed = ($urandom_range(99) < 8);
    sel = $urandom_range(99);
    if (sel < 50) it.ms = $urandom_range(5000);
    else if (sel < 80) it.ms = $urandom_range(2000000);
    else if (sel < 95) it.ms = $urandom_range(50000000);
    else it.ms = $urandom;
    sel = $urandom_range(99);
    if (sel < 30) begin
      m = ($urandom_range(1) ? int'(idle_thr_ma) : int'(band_ma)) + int'($urandom_range(2)) - 1;
      if (m < 0) m = 0;
      if (m > 32767) m = 32767;
      it.cur_ma = $urandom_range(1) ? CUR_W'(m) : CUR_W'(-m);
    end else if (sel < 70) begin
      it.cur_ma = CUR_W'(int'($urandom_range(10000)) - 5000);
    end else begin
      it.cur_ma = CUR_W'($urandom);
    end
    if (it.seed && $urandom_range(1)) begin
      t = int'(idle_thr_ma);
      it.cur_ma = CUR_W'(int'($urandom_range(2 * t)) - t);
    end
    sel = $urandom_range(99);
    lo = (vmin_mv < vmax_mv) ? int'(vmin_mv) : int'(vmax_mv);
    hi = (vmin_mv < vmax_mv) ? int'(vmax_mv) : int'(vmin_mv);
    if (sel < 20) begin
      m = ($urandom_range(1) ? lo : hi) + int'($urandom_range(4)) - 2;
    end else if (sel < 80) begin
      m = lo - 200 + int'($urandom_range(hi - lo + 400));
    end else begin
      m = $urandom_range(32000);
    end
    if (m < 0) m = 0;
    if (m > 32000) m = 32000;
    it.mv = VOLT_W'(m);
    return it;
  endfunction

  task automatic add_item(input bit seed, input logic [ELAPSED_W-1:0] ms,
                          input int cur, input int mv);
    soc_item_t it;
    it.seed   = seed;
    it.ms     = ms;
    it.cur_ma = CUR_W'(cur);
    it.mv     = VOLT_W'(mv);
    pending_q.push_back(it);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    case (idx)
      REG_CAPACITY:    cap_mah     = CAP_W'(val);
      REG_VOLTAGE_MIN: vmin_mv     = VOLT_W'(val);
      REG_VOLTAGE_MAX: vmax_mv     = VOLT_W'(val);
      REG_IDLE_THRESH: idle_thr_ma = VOLT_W'(val);
      REG_ALPHA_ACT:   alpha_act   = ALPHA_W'(val);
      REG_ALPHA_IDLE:  alpha_rest  = ALPHA_W'(val);
      REG_STATUS_BAND: band_ma     = VOLT_W'(val);
      default: ;
    endcase
  endtask

  task automatic write_all(input int cap, input int vlo, input int vhi, input int thr,
                           input int aa, input int ai, input int band);
    write_reg(REG_CAPACITY, cap);
    write_reg(REG_VOLTAGE_MIN, vlo);
    write_reg(REG_VOLTAGE_MAX, vhi);
    write_reg(REG_IDLE_THRESH, thr);
    write_reg(REG_ALPHA_ACT, aa);
    write_reg(REG_ALPHA_IDLE, ai);
    write_reg(REG_STATUS_BAND, band);
  endtask

  task automatic run_phase(input int n_items, input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (n_items) pending_q.push_back(random_item());
    while (pending_q.size() != 0 || in_valid || soc_expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // item driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        soc_expected_q.push_back(predict_soc(start_flag, elapsed_ms, battery_current_ma,
                                             battery_voltage_mv));
      end
      if (!in_valid || in_ready) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_item = pending_q.pop_front();
          in_valid           <= 1'b1;
          start_flag         <= next_item.seed;
          elapsed_ms         <= next_item.ms;
          battery_current_ma <= next_item.cur_ma;
          battery_voltage_mv <= next_item.mv;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (soc_expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("unexpected result beat: comb=%0d coul=%0d volt=%0d state=%0d",
                     combined_soc, coulomb_soc, voltage_soc, battery_state);
        end else begin
          want = soc_expected_q.pop_front();
          if (combined_soc !== want.combined || coulomb_soc !== want.coulomb ||
              voltage_soc !== want.voltage || battery_state !== want.bstate) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("mismatch: exp comb=%0d coul=%0d volt=%0d state=%0d, got comb=%0d coul=%0d volt=%0d state=%0d",
                       want.combined, want.coulomb, want.voltage, want.bstate,
                       combined_soc, coulomb_soc, voltage_soc, battery_state);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // no-progress watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_battery_soc_estimator_top NOT OK");
        $finish;
      end
    end
  end

  initial begin
    int send_tab[4];
    int recv_tab[4];
    int vlo;
    send_tab = '{0, 50, 0, 31};
    recv_tab = '{0, 0, 50, 31};
    rst = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // updates before any start, clamps, threshold and band edges, start seeding
    add_item(0, 1000, 1000, 3700);
    add_item(0, 0, 0, 0);
    add_item(0, 32'hFFFFFFFF, 32767, 32000);
    add_item(0, 32'hFFFFFFFF, -32768, 2999);
    add_item(1, 12345, 0, 3600);
    add_item(0, 60000, 50, 3650);
    add_item(0, 60000, 51, 3650);
    add_item(0, 60000, -51, 3650);
    add_item(0, 60000, -50, 3650);
    add_item(1, 0, 50, 4000);
    add_item(1, 0, -50, 4000);
    add_item(1, 0, 49, 4200);
    add_item(1, 0, -49, 3000);
    add_item(0, 3600000, -7000, 4300);
    add_item(1, 32'hFFFFFFFF, -32768, 0);
    add_item(0, 1, 1, 32000);
    add_item(0, 32'h80000000, 16384, 16384);
    add_item(0, 32'h55555555, -1, 21845);
    add_item(0, 32'hAAAAAAAA, 1, 10922);
    add_item(1, 0, 0, 32000);
    add_item(1, 0, 0, 0);
    run_phase(150, 0, 0);

    write_all(7000, 3000, 4200, 50, 230, 51, 50);
    run_phase(150, 50, 0);

    write_all(65535, 0, 32000, 32767, 256, 0, 32767);
    add_item(1, 0, -32768, 16000);
    add_item(1, 0, 32766, 16000);
    run_phase(150, 0, 50);

    // empty voltage span, smallest capacity
    write_all(1, 32000, 1, 0, 0, 256, 0);
    add_item(1, 0, 0, 20000);
    add_item(0, 1000, 0, 20000);
    run_phase(100, 31, 31);

    // zero capacity, weights above full scale
    write_all(0, 3500, 3500, 1000, 511, 300, 10);
    add_item(1, 0, 0, 3500);
    add_item(0, 5000, 2000, 3600);
    add_item(0, 5000, 10, 3400);
    run_phase(100, 0, 0);

    for (int k = 0; k < 4; k++) begin
      vlo = $urandom_range(16000);
      write_all($urandom_range(65535, 1), vlo, $urandom_range(32000, vlo + 1),
                $urandom_range(2000), $urandom_range(256), $urandom_range(256),
                $urandom_range(2000));
      run_phase(140, send_tab[k], recv_tab[k]);
    end

    if (mismatches == 0 && soc_expected_q.size() == 0) begin
      $display("tb_battery_soc_estimator_top OK");
    end else begin
      $display("tb_battery_soc_estimator_top NOT OK");
    end
    $finish;
  end

endmodule
